@@ design/sva_pkg.sv @@
// ----------------------------------------------------------------------------
// sva_pkg: shared types and constants of the sound voice allocator
// Opcodes, result codes, channel kind masks and the sequencer state type.
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;
    localparam int MAX_RES   = 6;

    localparam logic [31:0] TICK_STEP = 32'd512;
    localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;

    localparam logic [2:0] KIND_NORMAL = 3'b001;
    localparam logic [2:0] KIND_MOD    = 3'b011;
    localparam logic [2:0] KIND_NOISE  = 3'b100;

    typedef enum logic [1:0] {
        OP_REQ  = 2'd0,
        OP_TICK = 2'd1,
        OP_STOP = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EV_GRANT   = 2'd0,
        EV_REJECT  = 2'd1,
        EV_TIMEOUT = 2'd2,
        EV_STOPPED = 2'd3
    } ev_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_OWN   = 7'b0000010,
        ST_EXP   = 7'b0000100,
        ST_STEAL = 7'b0001000,
        ST_RESP  = 7'b0010000,
        ST_TICK  = 7'b0100000,
        ST_STOP  = 7'b1000000
    } state_t;

endpackage

@@ design/sound_voice_allocator_core.sv @@
// ----------------------------------------------------------------------------
// sound_voice_allocator_core: sound channel allocator
// Hands out channels by owner, expiry and priority stealing; frees on ticks.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one transaction per command. s_tuser holds the opcode
//   (request, tick, stop owner); s_tdata holds the request fields.
//   m_ channel: result transactions. m_tuser holds the event code,
//   m_tdata[2:0] the channel, m_tlast marks the final result of a command.
//   A request gives exactly one result; a tick or stop gives one result per
//   released or stopped channel (at most 6), or none. Unused opcodes do
//   nothing.
// Sequencing
//   One shared 32-bit signed comparator is walked over the channels by a
//   sequencer, one channel per cycle while no tick or stop scan stalls on
//   the output. A request runs the owner, expiry and steal scans in turn,
//   stopping at the first hit (skip omits the steal scan); a tick or stop
//   runs one scan. s_tready is high only while the sequencer is idle.
// Reset / stall
//   aresetn low frees every channel and clears the time. A result waits in
//   the output register while m_tready is low; the scan stalls only when it
//   needs that register for another result.
// ----------------------------------------------------------------------------
module sound_voice_allocator_core #(
    parameter int NUM_NORMAL     = 4,
    parameter int NUM_MODULATION = 1,
    parameter int NUM_NOISE      = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] requester_id, [34:32] source_type, [42:35] priority_req,
    // [43] skip, [75:44] duration
    input  logic [sva_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] op
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] channel
    output logic [sva_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] event_res
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import sva_pkg::*;

    localparam int NCH     = NUM_NORMAL + NUM_MODULATION + NUM_NOISE;
    localparam int NCH_ARR = (NCH < 1) ? 1 : NCH;
    localparam int CH_W    = (NCH_ARR < 2) ? 1 : $clog2(NCH_ARR);
    localparam int CNT_W   = $clog2(NCH + 2);

    function automatic logic [2:0] kind_mask(input logic [CH_W-1:0] i);
        if (int'(i) < NUM_NORMAL) begin
            return KIND_NORMAL;
        end else if (int'(i) < NUM_NORMAL + NUM_MODULATION) begin
            return KIND_MOD;
        end
        return KIND_NOISE;
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [31:0]        time_reg, time_next;
    logic [31:0]        id_reg, id_next;
    logic [2:0]         type_reg, type_next;
    logic [7:0]         prio_req_reg, prio_req_next;
    logic               skip_reg, skip_next;
    logic [31:0]        dur_reg, dur_next;
    logic               grant_reg, grant_next;
    logic [CH_W-1:0]    sel_reg, sel_next;
    logic               best_valid_reg, best_valid_next;
    logic [CH_W-1:0]    best_idx_reg, best_idx_next;
    logic [31:0]        best_dl_reg, best_dl_next;
    logic [2:0]         res_cnt_reg, res_cnt_next;
    logic               pend_valid_reg, pend_valid_next;
    ev_t                pend_ev_reg, pend_ev_next;
    logic [2:0]         pend_ch_reg, pend_ch_next;
    logic               out_valid_reg, out_valid_next;
    ev_t                out_ev_reg, out_ev_next;
    logic [2:0]         out_ch_reg, out_ch_next;
    logic               out_last_reg, out_last_next;

    logic [31:0]        owner_reg [NCH_ARR];
    logic [31:0]        dl_reg    [NCH_ARR];
    logic [7:0]         prio_reg  [NCH_ARR];

    logic               wr_grant, wr_free, wr_stop;
    logic [CH_W-1:0]    wr_idx;

    logic [CH_W-1:0]    idx_ch;
    logic               in_range;
    logic               kind_hit;
    logic [31:0]        dl_cur, own_cur;
    logic [7:0]         prio_cur;
    logic signed [31:0] cmp_a, cmp_b;
    logic               lt;
    logic               out_free;
    logic               hit, record, stall;

    assign idx_ch   = idx_reg[CH_W-1:0];
    assign in_range = idx_reg < CNT_W'(NCH);
    assign kind_hit = |(kind_mask(idx_ch) & type_reg);
    assign dl_cur   = dl_reg[idx_ch];
    assign own_cur  = owner_reg[idx_ch];
    assign prio_cur = prio_reg[idx_ch];
    assign out_free = !out_valid_reg || m_tready;

    // shared signed comparator
    always_comb begin
        cmp_a = $signed(dl_cur);
        cmp_b = $signed(time_reg);
        unique case (state_reg)
            ST_EXP: begin
                cmp_a = $signed(time_reg);
                cmp_b = $signed(dl_cur);
            end
            ST_STEAL: begin
                cmp_a = $signed(dl_cur);
                cmp_b = $signed(best_dl_reg);
            end
            default: begin
                cmp_a = $signed(dl_cur);
                cmp_b = $signed(time_reg);
            end
        endcase
    end
    assign lt = cmp_a < cmp_b;

    assign hit    = (state_reg == ST_TICK) ? (!dl_cur[31] && lt) : (own_cur == id_reg);
    assign record = res_cnt_reg < 3'(MAX_RES);
    assign stall  = record && pend_valid_reg && !out_free;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        time_next       = time_reg;
        id_next         = id_reg;
        type_next       = type_reg;
        prio_req_next   = prio_req_reg;
        skip_next       = skip_reg;
        dur_next        = dur_reg;
        grant_next      = grant_reg;
        sel_next        = sel_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_ch_next    = pend_ch_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_ev_next     = out_ev_reg;
        out_ch_next     = out_ch_reg;
        out_last_next   = out_last_reg;
        wr_grant        = 1'b0;
        wr_free         = 1'b0;
        wr_stop         = 1'b0;
        wr_idx          = idx_ch;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    id_next         = s_tdata[31:0];
                    type_next       = s_tdata[34:32];
                    prio_req_next   = s_tdata[42:35];
                    skip_next       = s_tdata[43];
                    dur_next        = s_tdata[75:44];
                    idx_next        = '0;
                    best_valid_next = 1'b0;
                    res_cnt_next    = '0;
                    pend_valid_next = 1'b0;
                    unique case (s_tuser)
                        OP_REQ:  state_next = ST_OWN;
                        OP_TICK: state_next = ST_TICK;
                        OP_STOP: state_next = ST_STOP;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OWN: begin
                if (!in_range) begin
                    idx_next   = '0;
                    state_next = ST_EXP;
                end else if (kind_hit && own_cur == id_reg) begin
                    grant_next = 1'b1;
                    sel_next   = idx_ch;
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EXP: begin
                if (!in_range) begin
                    idx_next = '0;
                    if (skip_reg) begin
                        grant_next = 1'b0;
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_STEAL;
                    end
                end else if (kind_hit && !lt) begin
                    grant_next = 1'b1;
                    sel_next   = idx_ch;
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_STEAL: begin
                if (!in_range) begin
                    grant_next = best_valid_reg;
                    sel_next   = best_idx_reg;
                    state_next = ST_RESP;
                end else begin
                    if (kind_hit && prio_cur <= prio_req_reg && (!best_valid_reg || lt)) begin
                        best_valid_next = 1'b1;
                        best_idx_next   = idx_ch;
                        best_dl_next    = dl_cur;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_ev_next    = grant_reg ? EV_GRANT : EV_REJECT;
                    out_ch_next    = grant_reg ? 3'(sel_reg) : 3'd0;
                    wr_grant       = grant_reg;
                    wr_idx         = sel_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_TICK, ST_STOP: begin
                if (!in_range) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            out_valid_next  = 1'b1;
                            out_last_next   = 1'b1;
                            out_ev_next     = pend_ev_reg;
                            out_ch_next     = pend_ch_reg;
                            pend_valid_next = 1'b0;
                        end
                        if (state_reg == ST_TICK) begin
                            time_next = time_reg + TICK_STEP;
                        end
                        state_next = ST_IDLE;
                    end
                end else if (!hit) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!stall) begin
                    wr_free = (state_reg == ST_TICK);
                    wr_stop = (state_reg == ST_STOP);
                    if (record) begin
                        if (pend_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_ev_next    = pend_ev_reg;
                            out_ch_next    = pend_ch_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_ev_next    = (state_reg == ST_TICK) ? EV_TIMEOUT : EV_STOPPED;
                        pend_ch_next    = 3'(idx_ch);
                        res_cnt_next    = res_cnt_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            time_reg       <= '0;
            grant_reg      <= 1'b0;
            best_valid_reg <= 1'b0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NCH_ARR; i++) begin
                owner_reg[i] <= FREE_MARK;
                dl_reg[i]    <= FREE_MARK;
                prio_reg[i]  <= '0;
            end
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            time_reg       <= time_next;
            grant_reg      <= grant_next;
            best_valid_reg <= best_valid_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wr_grant) begin
                owner_reg[wr_idx] <= id_reg;
                dl_reg[wr_idx]    <= time_reg + dur_reg;
                prio_reg[wr_idx]  <= prio_req_reg;
            end else if (wr_free) begin
                owner_reg[wr_idx] <= FREE_MARK;
                dl_reg[wr_idx]    <= FREE_MARK;
            end else if (wr_stop) begin
                dl_reg[wr_idx]    <= FREE_MARK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        type_reg     <= type_next;
        prio_req_reg <= prio_req_next;
        skip_reg     <= skip_next;
        dur_reg      <= dur_next;
        sel_reg      <= sel_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        pend_ev_reg  <= pend_ev_next;
        pend_ch_reg  <= pend_ch_next;
        out_ev_reg   <= out_ev_next;
        out_ch_reg   <= out_ch_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ev_reg;
    assign m_tdata  = {{(M_TDATA_W-3){1'b0}}, out_ch_reg};
    assign m_tlast  = out_last_reg;

endmodule

@@ design/sva_checker.sv @@
// ----------------------------------------------------------------------------
// sva_checker: port-level checks for the sound voice allocator
// Request result last flag, reject encoding, reset and output stall behavior.
// ----------------------------------------------------------------------------
module sva_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sva_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [1:0]                     m_tuser,
    input logic                           m_tlast
);
    import sva_pkg::*;

    // a stalled result transaction holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_rej_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_REJECT |-> m_tdata[2:0] == 3'd0)
        else $error("reject with nonzero channel");

    a_req_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == EV_GRANT || m_tuser == EV_REJECT) |-> m_tlast)
        else $error("request result not last");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sound_voice_allocator_core sva_checker u_sva_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/sv/sound_voice_allocator_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sound_voice_allocator_core_test: self-checking bench of the channel allocator
// Commands go in through a queue-fed stream driver. Each accepted transaction
// updates a local channel table (owner, deadline, priority, time) that gives
// the expected results. A monitor checks each result transaction in order.
// Both sides stall at random outside a calm window.
// ----------------------------------------------------------------------------
module sound_voice_allocator_core_test;
    import sva_pkg::*;

    localparam int NUM_NORMAL     = 4;
    localparam int NUM_MODULATION = 1;
    localparam int NUM_NOISE      = 1;
    localparam int NCH            = NUM_NORMAL + NUM_MODULATION + NUM_NOISE;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] WANT_NONE = 3'b000;
    localparam logic [2:0] WANT_MOD  = 3'b010;
    localparam logic [2:0] WANT_ALL  = 3'b111;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] id;
        logic [2:0]  kinds;
        logic [7:0]  prio;
        logic        skip;
        logic [31:0] dur;
        logic        hold;
    } cmd_t;

    typedef struct packed {
        ev_t        ev;
        logic [2:0] chan;
        logic       last;
    } res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;

    cmd_t cmd_queue[$];
    cmd_t cur_cmd;
    res_t result_q[$];
    int   error_count = 0;
    int   cyc_count = 0;
    logic calm;

    // channel table
    logic signed [31:0] clock_now;
    logic [31:0]        voice_owner[NCH];
    logic signed [31:0] voice_deadline[NCH];
    logic [7:0]         voice_prio[NCH];
    res_t               burst[MAX_RES];
    int                 burst_len;

    logic [31:0] owner_pool[6];

    sound_voice_allocator_core #(
        .NUM_NORMAL     (NUM_NORMAL),
        .NUM_MODULATION (NUM_MODULATION),
        .NUM_NOISE      (NUM_NOISE)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    assign calm = (cyc_count >= 1000) && (cyc_count < 2500);

    function automatic logic [2:0] kind_of(input int idx);
        if (idx < NUM_NORMAL) return KIND_NORMAL;
        if (idx < NUM_NORMAL + NUM_MODULATION) return KIND_MOD;
        return KIND_NOISE;
    endfunction

    function automatic int pick_voice(input cmd_t c);
        int best;
        best = -1;
        for (int i = 0; i < NCH; i++)
            if ((c.kinds & kind_of(i)) != 0 && voice_owner[i] == c.id) return i;
        for (int i = 0; i < NCH; i++)
            if ((c.kinds & kind_of(i)) != 0 && clock_now >= voice_deadline[i]) return i;
        if (c.skip) return -1;
        for (int i = 0; i < NCH; i++) begin
            if ((c.kinds & kind_of(i)) == 0 || voice_prio[i] > c.prio) continue;
            if (best < 0 || voice_deadline[i] < voice_deadline[best]) best = i;
        end
        return best;
    endfunction

    task automatic add_burst(input ev_t ev, input int ch);
        if (burst_len < MAX_RES) begin
            burst[burst_len] = '{ev: ev, chan: ch[2:0], last: 1'b0};
            burst_len++;
        end
    endtask

    task automatic predict_allocation(input cmd_t c);
        int ch;
        burst_len = 0;
        case (c.op)
            OP_REQ: begin
                ch = pick_voice(c);
                if (ch < 0) begin
                    add_burst(EV_REJECT, 0);
                end else begin
                    voice_owner[ch]    = c.id;
                    voice_deadline[ch] = clock_now + $signed(c.dur);
                    voice_prio[ch]     = c.prio;
                    add_burst(EV_GRANT, ch);
                end
            end
            OP_TICK: begin
                for (int i = 0; i < NCH; i++) begin
                    if (voice_deadline[i] >= 0 && clock_now > voice_deadline[i]) begin
                        voice_owner[i]    = FREE_MARK;
                        voice_deadline[i] = FREE_MARK;
                        add_burst(EV_TIMEOUT, i);
                    end
                end
                clock_now = clock_now + TICK_STEP;
            end
            OP_STOP: begin
                for (int i = 0; i < NCH; i++) begin
                    if (voice_owner[i] == c.id) begin
                        voice_deadline[i] = FREE_MARK;
                        add_burst(EV_STOPPED, i);
                    end
                end
            end
            default: ;
        endcase
        for (int i = 0; i < burst_len; i++) begin
            if (i == burst_len - 1) burst[i].last = 1'b1;
            result_q.push_back(burst[i]);
        end
    endtask

    task automatic push_cmd(input logic [1:0] op, input logic [31:0] id,
                            input logic [2:0] kinds, input logic [7:0] prio,
                            input logic skip, input logic [31:0] dur,
                            input logic hold);
        cmd_queue.push_back('{op: op, id: id, kinds: kinds, prio: prio,
                              skip: skip, dur: dur, hold: hold});
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_allocation(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= 30) &&
                    (!cmd_queue[0].hold || result_q.size() == 0)) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_cmd.op;
                    s_tdata  <= {4'b0, cur_cmd.dur, cur_cmd.skip, cur_cmd.prio,
                                 cur_cmd.kinds, cur_cmd.id};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t exp_res;
        cyc_count <= cyc_count + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result ev=%0d data=%0h last=%0b",
                             $time, m_tuser, m_tdata, m_tlast);
                    error_count++;
                end else begin
                    exp_res = result_q.pop_front();
                    if (m_tuser != exp_res.ev) begin
                        $display("%0t: event mismatch exp=%0d act=%0d",
                                 $time, exp_res.ev, m_tuser);
                        error_count++;
                    end
                    if (m_tdata != {{(M_TDATA_W-3){1'b0}}, exp_res.chan}) begin
                        $display("%0t: channel mismatch exp=%0d act=%0d",
                                 $time, exp_res.chan, m_tdata);
                        error_count++;
                    end
                    if (m_tlast != exp_res.last) begin
                        $display("%0t: last mismatch exp=%0b act=%0b",
                                 $time, exp_res.last, m_tlast);
                        error_count++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 30);
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int pick;
        logic [1:0]  op;
        logic [31:0] id;
        logic [31:0] dur;
        logic [2:0]  kinds;

        clock_now = '0;
        for (int i = 0; i < NCH; i++) begin
            voice_owner[i]    = FREE_MARK;
            voice_deadline[i] = FREE_MARK;
            voice_prio[i]     = '0;
        end
        owner_pool[0] = 32'h0;
        owner_pool[1] = FREE_MARK;
        owner_pool[2] = $urandom;
        owner_pool[3] = 32'd1;
        owner_pool[4] = 32'd2;
        owner_pool[5] = 32'hA5A5_5A5A;

        // directed
        push_cmd(OP_REQ,  32'd1, KIND_NORMAL, 8'd10, 1'b0, 32'd1000, 1'b0);
        push_cmd(OP_REQ,  32'd1, KIND_NORMAL, 8'd10, 1'b0, 32'd1500, 1'b0);
        push_cmd(OP_REQ,  32'd2, WANT_MOD,    8'd20, 1'b0, 32'd700, 1'b0);
        push_cmd(OP_REQ,  32'd3, KIND_NOISE,  8'd255, 1'b0, 32'h7FFF_FFFF, 1'b0);
        push_cmd(OP_REQ,  32'd4, KIND_NOISE,  8'd0, 1'b1, 32'd100, 1'b0);
        push_cmd(OP_REQ,  32'd4, KIND_NOISE,  8'd0, 1'b0, 32'd100, 1'b0);
        push_cmd(OP_REQ,  32'd5, WANT_NONE,   8'd255, 1'b0, 32'd100, 1'b0);
        push_cmd(OP_REQ,  FREE_MARK, WANT_ALL, 8'd50, 1'b0, 32'd600, 1'b0);
        push_cmd(OP_REQ,  32'd6, KIND_NORMAL, 8'd30, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_REQ,  32'd7, KIND_NORMAL, 8'd30, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_REQ,  32'd8, KIND_NORMAL, 8'd200, 1'b0, 32'h8000_0000, 1'b0);
        push_cmd(OP_REQ,  32'd9, KIND_NORMAL, 8'd255, 1'b1, 32'd400, 1'b0);
        push_cmd(OP_REQ,  32'd10, KIND_NORMAL, 8'd255, 1'b0, 32'd400, 1'b0);
        push_cmd(OP_REQ,  32'd11, KIND_NORMAL, 8'd0, 1'b0, 32'd400, 1'b0);
        push_cmd(OP_TICK, 32'd0, WANT_NONE, 8'd0, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_TICK, FREE_MARK, WANT_ALL, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
        push_cmd(OP_TICK, 32'd0, WANT_NONE, 8'd0, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_STOP, 32'd1, WANT_NONE, 8'd0, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_STOP, FREE_MARK, WANT_NONE, 8'd0, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_STOP, 32'hDEAD_BEEF, WANT_NONE, 8'd0, 1'b0, 32'd0, 1'b0);
        push_cmd(OP_UNUSED, 32'd2, WANT_ALL, 8'd255, 1'b1, 32'd5, 1'b0);
        push_cmd(OP_REQ,  32'd0, WANT_ALL, 8'd128, 1'b0, 32'd50, 1'b1);
        push_cmd(OP_TICK, 32'd0, WANT_NONE, 8'd0, 1'b0, 32'd0, 1'b0);

        // random: mostly requests from a small owner pool with short lifetimes
        for (int n = 0; n < 150; n++) begin
            pick = $urandom_range(99);
            if (pick < 55)      op = OP_REQ;
            else if (pick < 82) op = OP_TICK;
            else if (pick < 96) op = OP_STOP;
            else                op = OP_UNUSED;
            id = ($urandom_range(9) == 0) ? $urandom : owner_pool[$urandom_range(5)];
            kinds = ($urandom_range(9) == 0) ? WANT_NONE : 3'($urandom_range(7, 1));
            pick = $urandom_range(9);
            if (pick == 0)      dur = $urandom;
            else if (pick == 1) dur = -$urandom_range(2000);
            else                dur = $urandom_range(4000);
            push_cmd(op, id, kinds, 8'($urandom_range(255)),
                     $urandom_range(3) == 0, dur, (n % 40) == 39);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() > 0 || s_tvalid) @(posedge aclk);
        while (result_q.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0 && result_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
